/* rtl/avr_pkg.sv */
// Shared types and constants for the axis-angle vector rotation unit.
package avr_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle_rad;
  } avr_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               axis_zero;
  } avr_out_t;

  localparam int CordicIters = 30;
  localparam int CordW       = 34;
  localparam int RootSteps   = 32;
  localparam int QuoBits     = 32;

  localparam logic signed [CordW-1:0] RotPi     = 34'sd1686629713;
  localparam logic signed [CordW-1:0] RotHalfPi = 34'sd843314857;
  localparam logic signed [CordW-1:0] RotGain   = 34'sd652032874;

  // Arctangent of 2^-i in Q3.29.
  function automatic logic signed [CordW-1:0] atan_q29(input logic [4:0] idx);
    logic signed [CordW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd421657428;
      5'd1:    v = 34'sd248918915;
      5'd2:    v = 34'sd131521918;
      5'd3:    v = 34'sd66762579;
      5'd4:    v = 34'sd33510843;
      5'd5:    v = 34'sd16771758;
      5'd6:    v = 34'sd8387925;
      5'd7:    v = 34'sd4194219;
      5'd8:    v = 34'sd2097141;
      5'd9:    v = 34'sd1048575;
      default: v = $signed(34'd1) <<< (5'd29 - idx);
    endcase
    return v;
  endfunction

endpackage

/* rtl/avr_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per stage.
module avr_sqrt_pipe import avr_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o
);

  logic [63:0] res_q [RootSteps];
  logic [63:0] rem_q [RootSteps];

  for (genvar gk = 0; gk < RootSteps; gk++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * gk);
    logic [63:0] res_p, rem_p;
    logic [64:0] trial;

    if (gk == 0) begin : g_first
      assign res_p = '0;
      assign rem_p = x_i;
    end else begin : g_next
      assign res_p = res_q[gk-1];
      assign rem_p = rem_q[gk-1];
    end

    assign trial = {1'b0, res_p} + {1'b0, Bit};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, rem_p} >= trial) begin
          rem_q[gk] <= rem_p - trial[63:0];
          res_q[gk] <= (res_p >> 1) + Bit;
        end else begin
          rem_q[gk] <= rem_p;
          res_q[gk] <= res_p >> 1;
        end
      end
    end
  end

  assign root_o = res_q[RootSteps-1][31:0];

endmodule

/* rtl/avr_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
module avr_div_pipe import avr_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [62:0]         num_i,
  input  logic [31:0]         den_i,
  output logic [QuoBits-1:0]  quo_o
);

  logic [31:0]        rem_q [QuoBits];
  logic [31:0]        lo_q  [QuoBits];
  logic [QuoBits-1:0] quo_q [QuoBits];
  logic [31:0]        den_q [QuoBits];

  for (genvar gk = 0; gk < QuoBits; gk++) begin : g_step
    logic [31:0]        rem_p, lo_p, den_p;
    logic [QuoBits-1:0] quo_p;
    logic [32:0]        trial;
    logic               ge;

    if (gk == 0) begin : g_first
      assign rem_p = {1'b0, num_i[62:32]};
      assign lo_p  = num_i[31:0];
      assign quo_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_q[gk-1];
      assign lo_p  = lo_q[gk-1];
      assign quo_p = quo_q[gk-1];
      assign den_p = den_q[gk-1];
    end

    assign trial = {rem_p, lo_p[31]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gk] <= ge ? 32'(trial - {1'b0, den_p}) : trial[31:0];
        lo_q[gk]  <= lo_p << 1;
        quo_q[gk] <= {quo_p[QuoBits-2:0], ge};
        den_q[gk] <= den_p;
      end
    end
  end

  assign quo_o = quo_q[QuoBits-1];

endmodule

/* rtl/axis_angle_vector_rotate_unit.sv */
// Top level of the axis-angle vector rotation unit.
//
// Rotates a Q16.16 point about an arbitrary Q16.16 axis by a Q4.28 angle with the
// Euler-Rodrigues matrix. The unit accepts one request in every cycle while it is
// not stalled; each result passes through the 32-stage square root of the axis
// length, which runs alongside the 30-stage sine and cosine rotator, then through
// the 32-stage divider that scales the axis and the multiply stages that build and
// apply the matrix. The whole pipeline advances as one: when a finished result is
// held by out_stall_i, in_stall_o rises in the same cycle and every stage keeps its
// contents, so nothing is lost or repeated. A zero axis gives a zero point with
// axis_zero set; all results saturate to 32 bits.
module axis_angle_vector_rotate_unit import avr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  avr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output avr_out_t out_data_o
);

  localparam int Depth = 78;

  logic en;
  logic [Depth-1:0] vld_q;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en         = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // The request itself travels alongside for the point and axis values.
  avr_in_t in_q [76];

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q[0] <= in_data_i;
      for (int k = 1; k < 76; k++) begin
        in_q[k] <= in_q[k-1];
      end
    end
  end

  // Axis length: squares, then their sum.
  logic [63:0] sq_q [3];
  logic [63:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= 64'(in_data_i.axis_x * in_data_i.axis_x);
      sq_q[1] <= 64'(in_data_i.axis_y * in_data_i.axis_y);
      sq_q[2] <= 64'(in_data_i.axis_z * in_data_i.axis_z);
      sum_q   <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // Normalisation by even shifts so that the sum reaches at least 2^62.
  logic [63:0] nx_q [5];
  logic [4:0]  ne_q [5];

  for (genvar gj = 0; gj < 5; gj++) begin : g_norm
    localparam int Sh = 32 >> gj;
    logic [63:0] nx_p;
    logic [4:0]  ne_p;

    if (gj == 0) begin : g_first
      assign nx_p = sum_q;
      assign ne_p = '0;
    end else begin : g_next
      assign nx_p = nx_q[gj-1];
      assign ne_p = ne_q[gj-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (nx_p[63 -: Sh] == '0) begin
          nx_q[gj] <= nx_p << Sh;
          ne_q[gj] <= ne_p + 5'(Sh / 2);
        end else begin
          nx_q[gj] <= nx_p;
          ne_q[gj] <= ne_p;
        end
      end
    end
  end

  logic       zf_q [75];
  logic [4:0] ed_q [33];

  always_ff @(posedge clk_i) begin
    if (en) begin
      zf_q[0] <= (sum_q == '0);
      for (int k = 1; k < 75; k++) begin
        zf_q[k] <= zf_q[k-1];
      end
      ed_q[0] <= ne_q[4];
      for (int k = 1; k < 33; k++) begin
        ed_q[k] <= ed_q[k-1];
      end
    end
  end

  logic [31:0] root;

  avr_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (nx_q[4]),
    .root_o (root)
  );

  // Half angle: the raw angle read as Q3.29, folded into [-pi/2, pi/2].
  logic signed [CordW-1:0] hang;
  logic signed [CordW-1:0] cx_q [CordicIters+1];
  logic signed [CordW-1:0] cy_q [CordicIters+1];
  logic signed [CordW-1:0] cz_q [CordicIters+1];
  logic                    cn_q [CordicIters+1];

  assign hang = CordW'(in_data_i.angle_rad);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= RotGain;
      cy_q[0] <= '0;
      if (hang > RotHalfPi) begin
        cz_q[0] <= hang - RotPi;
        cn_q[0] <= 1'b1;
      end else if (hang < -RotHalfPi) begin
        cz_q[0] <= hang + RotPi;
        cn_q[0] <= 1'b1;
      end else begin
        cz_q[0] <= hang;
        cn_q[0] <= 1'b0;
      end
    end
  end

  for (genvar gi = 0; gi < CordicIters; gi++) begin : g_cordic
    logic signed [CordW-1:0] dx, dy, ang;

    assign dx  = cy_q[gi] >>> gi;
    assign dy  = cx_q[gi] >>> gi;
    assign ang = atan_q29(5'(gi));

    always_ff @(posedge clk_i) begin
      if (en) begin
        cn_q[gi+1] <= cn_q[gi];
        if (cz_q[gi] >= 0) begin
          cx_q[gi+1] <= cx_q[gi] - dx;
          cy_q[gi+1] <= cy_q[gi] + dy;
          cz_q[gi+1] <= cz_q[gi] - ang;
        end else begin
          cx_q[gi+1] <= cx_q[gi] + dx;
          cy_q[gi+1] <= cy_q[gi] - dy;
          cz_q[gi+1] <= cz_q[gi] + ang;
        end
      end
    end
  end

  // Cosine and sine of the half angle, with the fold's sign applied.
  logic signed [CordW-1:0] ac_q [43];
  logic signed [CordW-1:0] sc_q [8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ac_q[0] <= cn_q[CordicIters] ? -cx_q[CordicIters] : cx_q[CordicIters];
      sc_q[0] <= cn_q[CordicIters] ? -cy_q[CordicIters] : cy_q[CordicIters];
      for (int k = 1; k < 43; k++) begin
        ac_q[k] <= ac_q[k-1];
      end
      for (int k = 1; k < 8; k++) begin
        sc_q[k] <= sc_q[k-1];
      end
    end
  end

  // Axis times sine, scaled by the normalising power of two, as sign and magnitude.
  logic signed [31:0] axv [3];
  logic signed [65:0] prod_q [3];
  logic [62:0]        numm_q [3];
  logic [2:0]         sg_q [33];
  logic [31:0]        rd_q [2];

  assign axv[0] = in_q[38].axis_x;
  assign axv[1] = in_q[38].axis_y;
  assign axv[2] = in_q[38].axis_z;

  always_ff @(posedge clk_i) begin
    logic [65:0] mag;
    logic [96:0] shl;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= axv[i] * sc_q[7];
        mag       = prod_q[i][65] ? 66'(-prod_q[i]) : 66'(prod_q[i]);
        shl       = {31'b0, mag} << ed_q[32];
        numm_q[i] <= shl[62:0];
        sg_q[0][i] <= prod_q[i][65];
      end
      for (int k = 1; k < 33; k++) begin
        sg_q[k] <= sg_q[k-1];
      end
      rd_q[0] <= root;
      rd_q[1] <= rd_q[0];
    end
  end

  logic [QuoBits-1:0] quo [3];

  for (genvar gl = 0; gl < 3; gl++) begin : g_div
    avr_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (numm_q[gl]),
      .den_i (rd_q[1]),
      .quo_o (quo[gl])
    );
  end

  // Coefficients b, c, d (truncated toward zero), then the matrix.
  logic signed [CordW-1:0] bq_q [3];
  logic signed [67:0]      pr_q [10];
  logic signed [31:0]      m_q [3][3];
  logic signed [63:0]      mp_q [3][3];
  logic signed [31:0]      pv [3];

  function automatic logic signed [31:0] coef(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = (v + 68'sd536870912) >>> 30;
    if (t > 68'sd1073741824) begin
      t = 68'sd1073741824;
    end else if (t < -68'sd1073741824) begin
      t = -68'sd1073741824;
    end
    return t[31:0];
  endfunction

  assign pv[0] = in_q[75].point_x;
  assign pv[1] = in_q[75].point_y;
  assign pv[2] = in_q[75].point_z;

  always_ff @(posedge clk_i) begin
    logic signed [CordW-1:0] qs;
    logic signed [CordW-1:0] aq;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qs       = $signed({2'b00, quo[i]});
        bq_q[i] <= sg_q[32][i] ? -qs : qs;
      end
      aq = ac_q[42];
      pr_q[0] <= aq * aq;
      pr_q[1] <= bq_q[0] * bq_q[0];
      pr_q[2] <= bq_q[1] * bq_q[1];
      pr_q[3] <= bq_q[2] * bq_q[2];
      pr_q[4] <= bq_q[0] * bq_q[1];
      pr_q[5] <= aq * bq_q[2];
      pr_q[6] <= bq_q[0] * bq_q[2];
      pr_q[7] <= aq * bq_q[1];
      pr_q[8] <= bq_q[1] * bq_q[2];
      pr_q[9] <= aq * bq_q[0];

      m_q[0][0] <= coef(pr_q[0] + pr_q[1] - pr_q[2] - pr_q[3]);
      m_q[0][1] <= coef((pr_q[4] - pr_q[5]) <<< 1);
      m_q[0][2] <= coef((pr_q[6] + pr_q[7]) <<< 1);
      m_q[1][0] <= coef((pr_q[4] + pr_q[5]) <<< 1);
      m_q[1][1] <= coef(pr_q[0] + pr_q[2] - pr_q[1] - pr_q[3]);
      m_q[1][2] <= coef((pr_q[8] - pr_q[9]) <<< 1);
      m_q[2][0] <= coef((pr_q[6] - pr_q[7]) <<< 1);
      m_q[2][1] <= coef((pr_q[8] + pr_q[9]) <<< 1);
      m_q[2][2] <= coef(pr_q[0] + pr_q[3] - pr_q[1] - pr_q[2]);

      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mp_q[r][c] <= m_q[r][c] * pv[c];
        end
      end
    end
  end

  // Final sums, rounded to Q16.16 and saturated; a zero axis forces a zero point.
  function automatic logic signed [31:0] sat_out(input logic signed [65:0] acc);
    logic signed [65:0] t;
    t = (acc + 66'sd536870912) >>> 30;
    if (t > 66'sd2147483647) begin
      t = 66'sd2147483647;
    end else if (t < -66'sd2147483648) begin
      t = -66'sd2147483648;
    end
    return t[31:0];
  endfunction

  logic signed [65:0] acc [3];
  avr_out_t           out_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(mp_q[r][0]) + 66'(mp_q[r][1]) + 66'(mp_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zf_q[74]) begin
        out_q.rotated_x <= '0;
        out_q.rotated_y <= '0;
        out_q.rotated_z <= '0;
        out_q.axis_zero <= 1'b1;
      end else begin
        out_q.rotated_x <= sat_out(acc[0]);
        out_q.rotated_y <= sat_out(acc[1]);
        out_q.rotated_z <= sat_out(acc[2]);
        out_q.axis_zero <= 1'b0;
      end
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_data_o  = out_q;

endmodule
